/* src/mts_pkg.sv */
// mts_pkg: shared types, codes and constants of the micro token scanner
// no dependencies; used by mts_scanner, mts_token_queue and micro_token_scanner
package mts_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int OUT_BITS     = 16;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int QCNT_BITS    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_INT    = 4'd1,
    KIND_BEGIN  = 4'd2,
    KIND_END    = 4'd3,
    KIND_READ   = 4'd4,
    KIND_WRITE  = 4'd5,
    KIND_ASSIGN = 4'd6,
    KIND_MINUS  = 4'd7,
    KIND_PLUS   = 4'd8,
    KIND_LPAREN = 4'd9,
    KIND_RPAREN = 4'd10,
    KIND_SEMI   = 4'd11,
    KIND_COMMA  = 4'd12,
    KIND_ERROR  = 4'd13,
    KIND_EOF    = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_INT     = 3'd2,
    MODE_COLON   = 3'd3,
    MODE_MINUS   = 3'd4,
    MODE_COMMENT = 3'd5
  } mode_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  // keyword text, first character in the lowest byte
  localparam logic [39:0] KW_BEGIN = 40'h6E69676562;
  localparam logic [23:0] KW_END   = 24'h646E65;
  localparam logic [31:0] KW_READ  = 32'h64616572;
  localparam logic [39:0] KW_WRITE = 40'h6574697277;
  localparam int          KW_BYTES = 5;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef struct packed {
    kind_t                kind;
    logic [OUT_BITS-1:0]  start;
    logic [OUT_BITS-1:0]  length;
    logic                 last;
  } tok_t;

  // tokens handed from the scanner to the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  // clamp a position or length to the output field width
  function automatic logic [OUT_BITS-1:0] sat_out(input logic [31:0] v);
    logic [OUT_BITS-1:0] r;
    if (|v[31:OUT_BITS]) r = '1;
    else r = v[OUT_BITS-1:0];
    return r;
  endfunction

endpackage

/* src/micro_token_scanner.sv */
// micro_token_scanner: top level of the streaming lexical scanner
// depends on mts_pkg, mts_scanner and mts_token_queue
//
//  channel | direction | tdata                          | tuser      | tlast
//  --------+-----------+--------------------------------+------------+---------------
//  in_     | slave     | char_byte [7:0]                | command    | -
//  out_    | master    | kind, start, length (40 bits)  | -          | last of a run
//
// one byte is taken per cycle while in_tready is high; the scan state is updated from
// the input register once the queue has room, and the tokens go into a 4-entry queue
// a byte that yields two tokens puts both into the queue at once; they leave it one by one
// rst_n is synchronous and active low; it clears the scan mode, position and queue
// in_tready drops only while the input register holds a byte and the queue has
// fewer than two free entries
module micro_token_scanner #(
  parameter int POS_BITS = mts_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // [0] command: 0 text byte, 1 end of input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] token_kind, [19:4] token_start,
                                  // [35:20] token_length, [39:36] zero
  output logic        out_tlast   // run_last
);

  mts_pkg::push_t push;
  logic           room;

  // per-byte scan logic and pending token state
  mts_scanner #(
    .POS_BITS (POS_BITS)
  ) u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .room      (room),
    .push      (push)
  );

  // result queue, separates the scan from output stalls
  mts_token_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* src/mts_scanner.sv */
// mts_scanner: input register, scan state and per-byte token logic
// depends on mts_pkg; feeds mts_token_queue
module mts_scanner #(
  parameter int POS_BITS = mts_pkg::POS_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tuser,
  input  logic            room,
  output mts_pkg::push_t  push
);

  localparam int OUT_BITS_L = mts_pkg::OUT_BITS;

  logic                   item_v_r;
  logic                   item_cmd_r;
  logic [7:0]             item_byte_r;
  mts_pkg::mode_t         mode_r, mode_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [POS_BITS-1:0]    pstart_r, pstart_nxt;
  logic [POS_BITS-1:0]    plen_r, plen_nxt;
  logic [39:0]            prefix_r, prefix_nxt;
  logic                   take;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    logic [POS_BITS-1:0] r;
    if (&v) r = v;
    else r = v + POS_BITS'(1);
    return r;
  endfunction

  assign take      = item_v_r & room;
  assign in_tready = ~item_v_r | room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_cmd_r  <= in_tuser;
      item_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mts_pkg::MODE_IDLE;
      pos_r    <= '0;
      pstart_r <= '0;
      plen_r   <= '0;
      prefix_r <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      prefix_r <= prefix_nxt;
    end
  end

  always_comb begin
    logic [7:0]      c;
    logic            is_alpha, is_digit, is_space, word_ch;
    logic            flush_ok, flush_v, sec_v, do_fresh, do_ext;
    mts_pkg::tok_t   flush_tok, sec_tok;
    mts_pkg::kind_t  id_kind;
    logic [OUT_BITS_L-1:0] dummy;

    c        = item_byte_r;
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    is_digit = (c >= 8'h30 && c <= 8'h39);
    is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    word_ch  = is_alpha | is_digit | (c == mts_pkg::CH_UNDER);
    dummy    = '0;

    // exact keyword match on length and text
    if (plen_r == POS_BITS'(5) && prefix_r == mts_pkg::KW_BEGIN)
      id_kind = mts_pkg::KIND_BEGIN;
    else if (plen_r == POS_BITS'(3) && prefix_r[23:0] == mts_pkg::KW_END)
      id_kind = mts_pkg::KIND_END;
    else if (plen_r == POS_BITS'(4) && prefix_r[31:0] == mts_pkg::KW_READ)
      id_kind = mts_pkg::KIND_READ;
    else if (plen_r == POS_BITS'(5) && prefix_r == mts_pkg::KW_WRITE)
      id_kind = mts_pkg::KIND_WRITE;
    else id_kind = mts_pkg::KIND_IDENT;

    // token that the pending run turns into when it is cut off
    flush_tok.start  = mts_pkg::sat_out(32'(pstart_r));
    flush_tok.last   = 1'b0;
    flush_ok         = 1'b1;
    unique case (mode_r)
      mts_pkg::MODE_IDENT: begin
        flush_tok.kind   = id_kind;
        flush_tok.length = mts_pkg::sat_out(32'(plen_r));
      end
      mts_pkg::MODE_INT: begin
        flush_tok.kind   = mts_pkg::KIND_INT;
        flush_tok.length = mts_pkg::sat_out(32'(plen_r));
      end
      mts_pkg::MODE_COLON: begin
        flush_tok.kind   = mts_pkg::KIND_ERROR;
        flush_tok.length = OUT_BITS_L'(1);
      end
      mts_pkg::MODE_MINUS: begin
        flush_tok.kind   = mts_pkg::KIND_MINUS;
        flush_tok.length = OUT_BITS_L'(1);
      end
      default: begin
        flush_ok         = 1'b0;
        flush_tok.kind   = mts_pkg::KIND_ERROR;
        flush_tok.length = dummy;
      end
    endcase

    flush_v        = 1'b0;
    sec_v          = 1'b0;
    do_fresh       = 1'b0;
    do_ext         = 1'b0;
    sec_tok.kind   = mts_pkg::KIND_ERROR;
    sec_tok.start  = mts_pkg::sat_out(32'(pos_r));
    sec_tok.length = OUT_BITS_L'(1);
    sec_tok.last   = 1'b1;
    mode_nxt       = mode_r;
    pos_nxt        = sat_inc(pos_r);
    pstart_nxt     = pstart_r;
    plen_nxt       = plen_r;
    prefix_nxt     = prefix_r;

    if (item_cmd_r == mts_pkg::CMD_END) begin
      flush_v        = flush_ok;
      sec_v          = 1'b1;
      sec_tok.kind   = mts_pkg::KIND_EOF;
      sec_tok.length = '0;
      mode_nxt       = mts_pkg::MODE_IDLE;
      pos_nxt        = '0;
      pstart_nxt     = '0;
      plen_nxt       = '0;
      prefix_nxt     = '0;
    end else begin
      unique case (mode_r)
        mts_pkg::MODE_IDENT: begin
          if (word_ch) do_ext = 1'b1;
          else begin
            flush_v  = 1'b1;
            do_fresh = 1'b1;
          end
        end
        mts_pkg::MODE_INT: begin
          if (is_digit || c == mts_pkg::CH_UNDER) do_ext = 1'b1;
          else begin
            flush_v  = 1'b1;
            do_fresh = 1'b1;
          end
        end
        mts_pkg::MODE_COLON: begin
          if (c == mts_pkg::CH_EQ) begin
            sec_v          = 1'b1;
            sec_tok.kind   = mts_pkg::KIND_ASSIGN;
            sec_tok.start  = mts_pkg::sat_out(32'(pstart_r));
            sec_tok.length = OUT_BITS_L'(2);
            mode_nxt       = mts_pkg::MODE_IDLE;
          end else begin
            flush_v  = 1'b1;
            do_fresh = 1'b1;
          end
        end
        mts_pkg::MODE_MINUS: begin
          if (c == mts_pkg::CH_MINUS) mode_nxt = mts_pkg::MODE_COMMENT;
          else begin
            flush_v  = 1'b1;
            do_fresh = 1'b1;
          end
        end
        mts_pkg::MODE_COMMENT: begin
          if (c == mts_pkg::CH_NL) mode_nxt = mts_pkg::MODE_IDLE;
        end
        default: do_fresh = 1'b1;
      endcase

      if (do_ext) begin
        if (plen_r < POS_BITS'(mts_pkg::KW_BYTES)) begin
          prefix_nxt[{plen_r[2:0], 3'b000} +: 8] = c;
        end
        plen_nxt = sat_inc(plen_r);
      end

      if (do_fresh) begin
        mode_nxt = mts_pkg::MODE_IDLE;
        priority if (is_space) begin
          mode_nxt = mts_pkg::MODE_IDLE;
        end else if (is_alpha || is_digit || c == mts_pkg::CH_COLON ||
                     c == mts_pkg::CH_MINUS) begin
          priority if (is_alpha) mode_nxt = mts_pkg::MODE_IDENT;
          else if (is_digit) mode_nxt = mts_pkg::MODE_INT;
          else if (c == mts_pkg::CH_COLON) mode_nxt = mts_pkg::MODE_COLON;
          else mode_nxt = mts_pkg::MODE_MINUS;
          pstart_nxt = pos_r;
          plen_nxt   = POS_BITS'(1);
          prefix_nxt = {32'h0, c};
        end else begin
          sec_v = 1'b1;
          priority if (c == mts_pkg::CH_PLUS) sec_tok.kind = mts_pkg::KIND_PLUS;
          else if (c == mts_pkg::CH_LPAREN) sec_tok.kind = mts_pkg::KIND_LPAREN;
          else if (c == mts_pkg::CH_RPAREN) sec_tok.kind = mts_pkg::KIND_RPAREN;
          else if (c == mts_pkg::CH_SEMI) sec_tok.kind = mts_pkg::KIND_SEMI;
          else if (c == mts_pkg::CH_COMMA) sec_tok.kind = mts_pkg::KIND_COMMA;
          else sec_tok.kind = mts_pkg::KIND_ERROR;
        end
      end
    end

    push.cnt       = take ? ({1'b0, flush_v} + {1'b0, sec_v}) : 2'd0;
    push.tok0      = flush_v ? flush_tok : sec_tok;
    push.tok0.last = ~(flush_v & sec_v);
    push.tok1      = sec_tok;
  end

endmodule

/* src/mts_token_queue.sv */
// mts_token_queue: small token queue that takes up to two tokens a cycle while it has room for two
// depends on mts_pkg; drives the result stream of micro_token_scanner
module mts_token_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mts_pkg::push_t                push,
  output logic                          room,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,
  output logic                          out_tlast
);

  mts_pkg::tok_t                  q_r [mts_pkg::QDEPTH];
  logic [mts_pkg::QPTR_BITS-1:0]  wr_r, rd_r;
  logic [mts_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                           pop;
  mts_pkg::tok_t                  head;

  assign head       = q_r[rd_r];
  assign pop        = out_tvalid & out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {4'h0, head.length, head.start, head.kind};
  assign out_tlast  = head.last;
  // room for two tokens, whatever the head does this cycle
  assign room       = (cnt_r <= mts_pkg::QCNT_BITS'(mts_pkg::QDEPTH - 2));
  assign cnt_nxt    = cnt_r + mts_pkg::QCNT_BITS'(push.cnt)
                    - mts_pkg::QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + mts_pkg::QPTR_BITS'(push.cnt);
      rd_r  <= rd_r + mts_pkg::QPTR_BITS'(pop);
      cnt_r <= cnt_nxt;
    end
    if (push.cnt != 2'd0) q_r[wr_r] <= push.tok0;
    if (push.cnt == 2'd2) q_r[wr_r + mts_pkg::QPTR_BITS'(1)] <= push.tok1;
  end

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for micro_token_scanner, stream in and token stream out
// depends on mts_pkg and the micro_token_scanner rtl; keeps its own scanner model
// and checks every token transfer in order against it
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 300;   // long result-side hold-off
  localparam int RAND_ITEMS  = 1800;
  localparam int BURST_ITEMS = 300;   // random text sent with no idling
  localparam int TAIL_CYCLES = 20;

  // one text byte or an end command, as queued for the driver
  typedef struct packed {
    mts_pkg::cmd_t cmd;
    logic [7:0]    ch;
  } src_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_byte
  logic        in_tuser = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [3:0] kind, [19:4] start, [35:20] length, [39:36] zero
  logic        out_tlast;

  micro_token_scanner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // scanner model state, updated once per accepted input transfer
  // ---------------------------------------------------------------------------
  mts_pkg::mode_t cur_mode = mts_pkg::MODE_IDLE;
  logic [15:0]    cur_pos = '0;
  logic [15:0]    pend_start = '0;
  logic [15:0]    pend_len = '0;
  logic [39:0]    kw_buf = '0;      // first five bytes of the pending word
  mts_pkg::tok_t  step_tok [2];     // tokens caused by the current byte
  int             n_step;

  src_item_t      src_text_q [$];   // items waiting for the driver
  mts_pkg::tok_t  tok_due_q [$];    // tokens the block still owes us

  // run bookkeeping
  int src_pushed = 0;
  int src_taken = 0;
  int tok_seen = 0;
  int kw_seen = 0;
  int err_seen = 0;
  int eof_seen = 0;
  int mism_cnt = 0;
  int stall_cnt = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 22;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  mts_pkg::tok_t got_tok;
  mts_pkg::tok_t want_tok;
  src_item_t drv_item;

  string kw_word [4] = '{"begin", "end", "read", "write"};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // saturating step of a position or length
  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  // keywords only on an exact match of length and text
  function automatic mts_pkg::kind_t word_kind();
    mts_pkg::kind_t k;
    k = mts_pkg::KIND_IDENT;
    if (pend_len == 16'd5 && kw_buf == mts_pkg::KW_BEGIN) k = mts_pkg::KIND_BEGIN;
    else if (pend_len == 16'd3 && kw_buf[23:0] == mts_pkg::KW_END) k = mts_pkg::KIND_END;
    else if (pend_len == 16'd4 && kw_buf[31:0] == mts_pkg::KW_READ) k = mts_pkg::KIND_READ;
    else if (pend_len == 16'd5 && kw_buf == mts_pkg::KW_WRITE) k = mts_pkg::KIND_WRITE;
    return k;
  endfunction

  task automatic emit_tok(input mts_pkg::kind_t k, input logic [15:0] s,
                          input logic [15:0] l);
    step_tok[n_step].kind   = k;
    step_tok[n_step].start  = s;
    step_tok[n_step].length = l;
    step_tok[n_step].last   = 1'b0;
    n_step++;
  endtask

  task automatic flush_pending();
    case (cur_mode)
      mts_pkg::MODE_IDENT: emit_tok(word_kind(), pend_start, pend_len);
      mts_pkg::MODE_INT:   emit_tok(mts_pkg::KIND_INT, pend_start, pend_len);
      mts_pkg::MODE_COLON: emit_tok(mts_pkg::KIND_ERROR, pend_start, 16'd1);
      mts_pkg::MODE_MINUS: emit_tok(mts_pkg::KIND_MINUS, pend_start, 16'd1);
      default: ;
    endcase
    cur_mode = mts_pkg::MODE_IDLE;
  endtask

  task automatic open_pending(input mts_pkg::mode_t m, input logic [7:0] c);
    cur_mode   = m;
    pend_start = cur_pos;
    pend_len   = 16'd1;
    kw_buf     = {32'd0, c};
  endtask

  task automatic grow_pending(input logic [7:0] c);
    if (pend_len < mts_pkg::KW_BYTES) kw_buf[pend_len*8 +: 8] = c;
    pend_len = bump(pend_len);
  endtask

  // a byte seen with nothing pending
  task automatic scan_fresh(input logic [7:0] c);
    if (is_space(c)) return;
    if (is_alpha(c)) begin
      open_pending(mts_pkg::MODE_IDENT, c);
      return;
    end
    if (is_digit(c)) begin
      open_pending(mts_pkg::MODE_INT, c);
      return;
    end
    case (c)
      mts_pkg::CH_COLON:  open_pending(mts_pkg::MODE_COLON, c);
      mts_pkg::CH_MINUS:  open_pending(mts_pkg::MODE_MINUS, c);
      mts_pkg::CH_PLUS:   emit_tok(mts_pkg::KIND_PLUS, cur_pos, 16'd1);
      mts_pkg::CH_LPAREN: emit_tok(mts_pkg::KIND_LPAREN, cur_pos, 16'd1);
      mts_pkg::CH_RPAREN: emit_tok(mts_pkg::KIND_RPAREN, cur_pos, 16'd1);
      mts_pkg::CH_SEMI:   emit_tok(mts_pkg::KIND_SEMI, cur_pos, 16'd1);
      mts_pkg::CH_COMMA:  emit_tok(mts_pkg::KIND_COMMA, cur_pos, 16'd1);
      default:            emit_tok(mts_pkg::KIND_ERROR, cur_pos, 16'd1);
    endcase
  endtask

  // advance the scanner model by one transfer and queue the tokens it owes
  task automatic lex_byte(input mts_pkg::cmd_t cmd, input logic [7:0] c);
    logic rescan;
    rescan = 1'b1;
    n_step = 0;
    if (cmd == mts_pkg::CMD_END) begin
      // pending token, then eof, then back to position zero
      flush_pending();
      emit_tok(mts_pkg::KIND_EOF, cur_pos, 16'd0);
      cur_mode   = mts_pkg::MODE_IDLE;
      cur_pos    = '0;
      pend_start = '0;
      pend_len   = '0;
      kw_buf     = '0;
    end else begin
      case (cur_mode)
        mts_pkg::MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == mts_pkg::CH_UNDER) begin
            grow_pending(c);
            rescan = 1'b0;
          end else flush_pending();
        end
        mts_pkg::MODE_INT: begin
          if (is_digit(c) || c == mts_pkg::CH_UNDER) begin
            grow_pending(c);
            rescan = 1'b0;
          end else flush_pending();
        end
        mts_pkg::MODE_COLON: begin
          if (c == mts_pkg::CH_EQ) begin
            emit_tok(mts_pkg::KIND_ASSIGN, pend_start, 16'd2);
            cur_mode = mts_pkg::MODE_IDLE;
            rescan = 1'b0;
          end else flush_pending();  // lone colon is an error, byte rescanned
        end
        mts_pkg::MODE_MINUS: begin
          if (c == mts_pkg::CH_MINUS) begin
            cur_mode = mts_pkg::MODE_COMMENT;
            rescan = 1'b0;
          end else flush_pending();
        end
        mts_pkg::MODE_COMMENT: begin
          if (c == mts_pkg::CH_NL) cur_mode = mts_pkg::MODE_IDLE;
          rescan = 1'b0;
        end
        default: cur_mode = mts_pkg::MODE_IDLE;
      endcase
      if (rescan) scan_fresh(c);
      cur_pos = bump(cur_pos);
    end
    if (n_step != 0) step_tok[n_step-1].last = 1'b1;
    for (int i = 0; i < n_step; i++) tok_due_q.push_back(step_tok[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] c);
    src_text_q.push_back(src_item_t'{cmd: mts_pkg::CMD_BYTE, ch: c});
    src_pushed++;
  endtask

  // end command; the byte field carries noise so its bits still toggle
  task automatic put_end();
    src_text_q.push_back(src_item_t'{cmd: mts_pkg::CMD_END,
                                     ch: 8'($urandom_range(0, 255))});
    src_pushed++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 52) return rand_letter();
    if (r < 62) return 8'("0" + r - 52);
    return mts_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'h20 : 8'(r);
  endfunction

  // one lexeme, mostly well formed, sometimes noise or a broken sequence
  task automatic gen_lexeme();
    int pick;
    int n;
    string s;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      s = kw_word[$urandom_range(0, 3)];
      case ($urandom_range(0, 5))
        0, 1: put_text(s);                          // exact keyword
        2:    put_text(s.substr(0, s.len() - 2));   // keyword prefix
        3: begin                                    // keyword with a tail
          put_text(s);
          put_byte(rand_word_char());
        end
        default: begin
          put_byte(rand_letter());
          n = $urandom_range(0, 8);
          repeat (n) put_byte(rand_word_char());
        end
      endcase
    end else if (pick < 40) begin
      put_byte(8'("0" + $urandom_range(0, 9)));
      n = $urandom_range(0, 5);
      repeat (n) put_byte(($urandom_range(0, 4) == 0) ? mts_pkg::CH_UNDER
                                                      : 8'("0" + $urandom_range(0, 9)));
    end else if (pick < 50) begin
      case ($urandom_range(0, 6))
        0: begin
          put_byte(mts_pkg::CH_COLON);
          put_byte(mts_pkg::CH_EQ);
        end
        1: put_byte(mts_pkg::CH_MINUS);
        2: put_byte(mts_pkg::CH_PLUS);
        3: put_byte(mts_pkg::CH_LPAREN);
        4: put_byte(mts_pkg::CH_RPAREN);
        5: put_byte(mts_pkg::CH_SEMI);
        default: put_byte(mts_pkg::CH_COMMA);
      endcase
    end else if (pick < 70) begin
      n = $urandom_range(1, 3);
      repeat (n) put_byte(rand_space());
    end else if (pick < 78) begin
      // comment, left open now and then
      put_byte(mts_pkg::CH_MINUS);
      put_byte(mts_pkg::CH_MINUS);
      n = $urandom_range(0, 6);
      repeat (n) put_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 4) != 0) put_byte(mts_pkg::CH_NL);
    end else if (pick < 90) begin
      put_byte(8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      put_byte(($urandom_range(0, 1) == 0) ? mts_pkg::CH_COLON : mts_pkg::CH_MINUS);
      put_byte(($urandom_range(0, 1) == 0) ? rand_word_char() : rand_space());
    end else begin
      put_end();
    end
    if ($urandom_range(0, 1) == 0) put_byte(rand_space());
  endtask

  // sender pauses here until every pushed item is taken and every token is back
  task automatic wait_drained();
    while (src_taken != src_pushed || tok_due_q.size() != 0) @(negedge clk);
  endtask

  task automatic note_mismatch(input string what, input mts_pkg::tok_t want,
                               input mts_pkg::tok_t got);
    mism_cnt++;
    if (mism_cnt <= 10) begin
      $display("%0t mismatch (%s): want kind %0d start %0d len %0d last %0b",
               $realtime, what, want.kind, want.start, want.length, want.last);
      $display("  got kind %0d start %0d len %0d last %0b pad %h",
               got.kind, got.start, got.length, got.last, out_tdata[39:36]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued items, changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      // slot is free: either nothing was offered or the last offer was taken
      if (src_text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = src_text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_item.cmd;
        in_tdata  <= drv_item.ch;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge, checks tokens, feeds
  // the model with accepted input, and watches for a stuck run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      out_fire = out_tvalid && out_tready;
      in_fire  = in_tvalid && in_tready;
      if (out_fire) begin
        got_tok.kind   = mts_pkg::kind_t'(out_tdata[3:0]);
        got_tok.start  = out_tdata[19:4];
        got_tok.length = out_tdata[35:20];
        got_tok.last   = out_tlast;
        tok_seen++;
        if (got_tok.kind >= mts_pkg::KIND_BEGIN && got_tok.kind <= mts_pkg::KIND_WRITE)
          kw_seen++;
        if (got_tok.kind == mts_pkg::KIND_ERROR) err_seen++;
        if (got_tok.kind == mts_pkg::KIND_EOF) eof_seen++;
        if (tok_due_q.size() == 0) begin
          note_mismatch("no token due", '0, got_tok);
        end else begin
          want_tok = tok_due_q.pop_front();
          if (got_tok !== want_tok || out_tdata[39:36] !== 4'd0)
            note_mismatch("field", want_tok, got_tok);
        end
      end
      // a token can never leave in the cycle its byte is taken, so order here is free
      if (in_fire) begin
        src_taken++;
        lex_byte(mts_pkg::cmd_t'(in_tuser), in_tdata);
      end
      if (in_fire || out_fire) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer, %0d tokens still due",
                 stall_cnt, tok_due_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: reset, directed text, burst without idling, random text, wrap-up
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: keyword ended by a byte gives two tokens, assign, int with
    // underscore, colon without equals, lone minus, leading underscore and
    // a non-ascii byte, then end with a pending word, an open comment,
    // a pending colon and a pending minus
    put_text("read;");
    put_text(":=");
    put_text("(9_,");
    put_text(":a-+");
    put_byte(mts_pkg::CH_UNDER);
    put_byte(8'hFF);
    put_byte(mts_pkg::CH_RPAREN);
    put_byte("w");
    put_end();
    put_byte(mts_pkg::CH_MINUS);
    put_byte(mts_pkg::CH_MINUS);
    put_end();
    put_byte(mts_pkg::CH_COLON);
    put_end();
    put_byte(mts_pkg::CH_MINUS);
    put_end();
    wait_drained();

    // back-to-back stretch: no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (src_pushed < BURST_ITEMS) gen_lexeme();
    wait_drained();
    send_idle_pct = 22;
    recv_idle_pct = 22;

    // random part in three slices: the first carries a long receiver hold-off
    // while the sender keeps offering, the second ends in a full drain
    while (src_pushed < 700) gen_lexeme();
    while (src_text_q.size() > 300) @(negedge clk);
    hold_req++;
    while (src_pushed < 1300) gen_lexeme();
    wait_drained();
    while (src_pushed < RAND_ITEMS) gen_lexeme();
    put_end();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tok_due_q.size() != 0) mism_cnt++;

    $display("covered %0d input transfers and %0d tokens (%0d keywords, %0d errors, %0d eof),",
             src_taken, tok_seen, kw_seen, err_seen, eof_seen);
    $display("including a burst with no idling, a long result hold-off and drains; %0d mismatches",
             mism_cnt);
    if (mism_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
